[design/hdlc_frame_encoder_assert.svh]
// Assertion macros for the HDLC frame encoder, used by hdlc_ser.
// Expects clk and rst_n in the scope of use.
`ifndef HDLC_FRAME_ENCODER_ASSERT_SVH
`define HDLC_FRAME_ENCODER_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define HDLC_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hdlc assertion failed");

// consequent holds in the cycle after the antecedent
`define HDLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hdlc assertion failed");

`endif

[design/hdlc_pkg.sv]
// Package for the HDLC frame encoder: framing constants, FCS-16 update,
// and the byte-sequence type passed from builder to serialiser. No dependencies.
package hdlc_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] FCS_POLY  = 16'h8408;
  localparam logic [15:0] FCS_INIT  = 16'hFFFF;
  localparam int          SEQ_MAX   = 8;
  localparam int          SEQ_IDX_W = $clog2(SEQ_MAX);

  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] bytes;
    logic [SEQ_IDX_W-1:0]    last_idx;
    logic                    closes;
  } seq_t;

  function automatic logic [15:0] fcs_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

endpackage

[design/hdlc_frm_build.sv]
// Frame builder: keeps the running FCS and frame state, and turns one
// payload item into its escaped line-byte sequence. Uses hdlc_pkg.
module hdlc_frm_build (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    payload_byte,
  input  logic          payload_end,
  output hdlc_pkg::seq_t seq
);

  logic [15:0] crc_r, crc_nxt;
  logic        open_r, open_nxt;
  logic [15:0] crc_upd;
  logic [15:0] fcs;

  logic [4:0][7:0] seg_byte;
  logic [4:0]      seg_en;
  logic [4:0]      seg_esc;

  assign crc_upd = hdlc_pkg::fcs_update(crc_r, payload_byte);
  assign fcs     = ~crc_upd;

  always_comb begin
    seg_byte = {hdlc_pkg::FLAG_BYTE, fcs[15:8], fcs[7:0], payload_byte,
                hdlc_pkg::FLAG_BYTE};
    seg_en   = {payload_end, payload_end, payload_end, 1'b1, ~open_r};
    seg_esc  = {1'b0, hdlc_pkg::needs_esc(fcs[15:8]), hdlc_pkg::needs_esc(fcs[7:0]),
                hdlc_pkg::needs_esc(payload_byte), 1'b0};
  end

  always_comb begin
    logic [3:0]                     n;
    logic [hdlc_pkg::SEQ_IDX_W-1:0] p;
    n         = 4'd0;
    p         = '0;
    seq.bytes = '0;
    for (int s = 0; s < 5; s++) begin
      p = n[hdlc_pkg::SEQ_IDX_W-1:0];
      if (seg_en[s]) begin
        if (seg_esc[s]) begin
          seq.bytes[p]        = hdlc_pkg::ESC_BYTE;
          seq.bytes[p + 3'd1] = seg_byte[s] ^ hdlc_pkg::ESC_XOR;
          n = n + 4'd2;
        end else begin
          seq.bytes[p] = seg_byte[s];
          n = n + 4'd1;
        end
      end
    end
    seq.last_idx = 3'(n - 4'd1);
    seq.closes   = payload_end;
  end

  always_comb begin
    crc_nxt  = crc_r;
    open_nxt = open_r;
    if (take) begin
      crc_nxt  = payload_end ? hdlc_pkg::FCS_INIT : crc_upd;
      open_nxt = ~payload_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= hdlc_pkg::FCS_INIT;
      open_r <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

[design/hdlc_ser.sv]
// Serialiser: holds one item's byte sequence and feeds it, one byte a cycle
// while out_stall is low, into the output register. Uses hdlc_pkg and the assertion header.
`include "hdlc_frame_encoder_assert.svh"

module hdlc_ser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hdlc_pkg::seq_t seq,
  output logic           load,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_line_byte,
  output logic           out_run_last,
  output logic           out_frame_done
);

  hdlc_pkg::seq_t                 buf_r, buf_nxt;
  logic                           buf_valid_r, buf_valid_nxt;
  logic [hdlc_pkg::SEQ_IDX_W-1:0] idx_r, idx_nxt;
  logic                           out_valid_r;
  logic [7:0]                     out_byte_r;
  logic                           out_run_last_r;
  logic                           out_frame_done_r;
  logic                           out_adv, move, last_move, at_last;

  assign at_last   = (idx_r == buf_r.last_idx);
  assign out_adv   = ~out_valid_r | ~out_stall;
  assign move      = buf_valid_r & out_adv;
  assign last_move = move & at_last;
  assign in_stall  = buf_valid_r & ~last_move;
  assign load      = in_valid & ~in_stall;

  always_comb begin
    buf_nxt       = buf_r;
    buf_valid_nxt = buf_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      buf_nxt       = seq;
      buf_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (last_move) begin
      buf_valid_nxt = 1'b0;
    end else if (move) begin
      idx_nxt = idx_r + {{(hdlc_pkg::SEQ_IDX_W-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      buf_valid_r <= buf_valid_nxt;
      idx_r       <= idx_nxt;
      if (out_adv) begin
        out_valid_r <= buf_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (out_adv) begin
      out_byte_r       <= buf_r.bytes[idx_r];
      out_run_last_r   <= at_last;
      out_frame_done_r <= at_last & buf_r.closes;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_byte  = out_byte_r;
  assign out_run_last   = out_run_last_r;
  assign out_frame_done = out_frame_done_r;

  `HDLC_ASSERT_HOLDS(a_idx_in_range, buf_valid_r, idx_r <= buf_r.last_idx)
  `HDLC_ASSERT_HOLDS(a_done_is_last, out_valid_r && out_frame_done_r, out_run_last_r)
  `HDLC_ASSERT_HOLDS(a_done_is_flag, out_valid_r && out_frame_done_r,
                     out_byte_r == hdlc_pkg::FLAG_BYTE)
  `HDLC_ASSERT_NEXT(a_drain_empties, last_move && !load, !buf_valid_r)

endmodule

[design/hdlc_frame_encoder.sv]
// HDLC frame encoder, top level: asynchronous HDLC framing with FCS-16.
// Instantiates hdlc_frm_build and hdlc_ser; uses hdlc_pkg.
//
// Input channel: one payload byte per item, in_payload_end marks the frame's
// last byte. Output channel: one line byte per item, with out_run_last on the
// final byte caused by an input item and out_frame_done on the closing flag.
// An item produces 1 to 8 line bytes: optional opening flag, the escaped
// payload byte and, at frame end, the escaped FCS (low byte first) and flag.
// An accepted item is registered in the sequence buffer and its first line byte
// then in the output register. Throughput: one line byte per cycle while
// out_stall is low (a mid-frame item has one or two line bytes); the next item
// is taken in the cycle its predecessor's last byte moves to the output register.
// Reset: FCS register loads 0xFFFF, no frame open, both stages empty.
// A stall on the output holds the output register; the sequence buffer then
// fills and in_stall rises until the line side drains.
module hdlc_frame_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_payload_byte,
  input  logic       in_payload_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_line_byte,
  output logic       out_run_last,
  output logic       out_frame_done
);

  hdlc_pkg::seq_t seq;
  logic           load;

  hdlc_frm_build u_build (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (load),
    .payload_byte (in_payload_byte),
    .payload_end  (in_payload_end),
    .seq          (seq)
  );

  hdlc_ser u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .seq            (seq),
    .load           (load),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_byte  (out_line_byte),
    .out_run_last   (out_run_last),
    .out_frame_done (out_frame_done)
  );

endmodule
